// ----- rtl/htrp_pkg.sv -----
// ----------------------------------------------------------------------------
// htrp_pkg
// Shared types and constants for the hex tick reply parser.
// ----------------------------------------------------------------------------
package htrp_pkg;

    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [2:0] ECHO_BYTES = 3'd4;
    localparam logic       REQ_START  = 1'b0;
    localparam logic       REQ_BYTE   = 1'b1;

    typedef struct packed {
        logic signed [31:0] tick_count;
        logic [3:0]         digit_count;
        logic               malformed;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok     = 1'b1;
        h.nibble = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.nibble = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.nibble = 4'(b - 8'h41 + 8'd10);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.nibble = 4'(b - 8'h61 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/htrp_if.sv -----
// ----------------------------------------------------------------------------
// htrp_in_if / htrp_out_if
// Valid/ready channels for received bytes and parsed replies.
// ----------------------------------------------------------------------------
interface htrp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface htrp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tick_count;
    logic [3:0]         digit_count;
    logic               malformed;

    modport source (output valid, output tick_count, output digit_count,
                    output malformed, input ready);
    modport sink   (input valid, input tick_count, input digit_count,
                    input malformed, output ready);
endinterface

// ----- rtl/htrp_parser.sv -----
// ----------------------------------------------------------------------------
// htrp_parser
// Parser state and per-byte update; flags a result at the terminator byte.
// ----------------------------------------------------------------------------
module htrp_parser
    import htrp_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_req_type,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int DW = $clog2(MAX_DIGITS + 1);
    localparam logic [DW-1:0] MAX_CNT = DW'(MAX_DIGITS);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_ECHO   = 3'b010,
        PH_DIGITS = 3'b100
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [2:0]     r_echo_left, n_echo_left;
    logic           r_first_seen, n_first_seen;
    logic [31:0]    r_acc, n_acc;
    logic [DW-1:0]  r_digits, n_digits;
    logic           r_negative, n_negative;
    logic           r_bad, n_bad;

    t_hex        hex;
    logic        skip_cr;
    logic [2:0]  echo_dec;
    logic [4:0]  digits_wide;
    logic [31:0] ext_value;

    assign hex         = hex_decode(i_rx_byte);
    assign digits_wide = 5'(r_digits);

    // nibbles above the received digits are filled with ones when negative
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (r_negative && 5'(i) >= digits_wide) begin
                ext_value[4*i +: 4] = 4'hF;
            end else begin
                ext_value[4*i +: 4] = r_acc[4*i +: 4];
            end
        end
    end

    always_comb begin
        o_res.tick_count  = ext_value;
        o_res.digit_count = (digits_wide > 5'd15) ? 4'hF : digits_wide[3:0];
        o_res.malformed   = r_bad;
    end

    always_comb begin
        n_phase      = r_phase;
        n_echo_left  = r_echo_left;
        n_first_seen = r_first_seen;
        n_acc        = r_acc;
        n_digits     = r_digits;
        n_negative   = r_negative;
        n_bad        = r_bad;
        o_res_valid  = 1'b0;
        skip_cr      = !r_first_seen && i_rx_byte == CR_BYTE;
        echo_dec     = (!skip_cr && r_echo_left != 3'd0) ? r_echo_left - 3'd1
                                                         : r_echo_left;
        if (i_take) begin
            if (i_req_type == REQ_START) begin
                n_phase      = PH_ECHO;
                n_echo_left  = ECHO_BYTES;
                n_first_seen = 1'b0;
                n_acc        = '0;
                n_digits     = '0;
                n_negative   = 1'b0;
                n_bad        = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_ECHO: begin
                        n_first_seen = 1'b1;
                        n_echo_left  = echo_dec;
                        if (echo_dec == 3'd0) begin
                            n_phase = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (r_digits >= MAX_CNT || i_rx_byte == CR_BYTE) begin
                            o_res_valid = 1'b1;
                            n_phase     = PH_IDLE;
                        end else if (!r_bad) begin
                            if (!hex.ok) begin
                                n_bad = 1'b1;
                            end else begin
                                if (r_digits == '0 && hex.nibble[3]) begin
                                    n_negative = 1'b1;
                                end
                                n_acc    = {r_acc[27:0], hex.nibble};
                                n_digits = r_digits + DW'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_echo_left  <= '0;
            r_first_seen <= 1'b0;
            r_acc        <= '0;
            r_digits     <= '0;
            r_negative   <= 1'b0;
            r_bad        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_echo_left  <= n_echo_left;
            r_first_seen <= n_first_seen;
            r_acc        <= n_acc;
            r_digits     <= n_digits;
            r_negative   <= n_negative;
            r_bad        <= n_bad;
        end
    end

endmodule

// ----- rtl/hex_tick_reply_parser_unit.sv -----
// ----------------------------------------------------------------------------
// hex_tick_reply_parser_unit
// Parses an encoder-count reply byte by byte into a signed tick count.
// ----------------------------------------------------------------------------
// a result reaches the output register after its terminating word passes
// through the input register and is taken by the parser
// throughput: one word per cycle while the output is not stalled, set by the parser state update
// a full output register only holds back the input while the result is not taken
// reset: synchronous active-low; parser goes idle, input ready rises in the cycle
// after reset is released
module hex_tick_reply_parser_unit
    import htrp_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    htrp_in_if.sink         i_in,
    htrp_out_if.source      o_out
);

    logic       r_live;
    logic       r_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic    stall;
    logic    take;
    logic    res_valid;
    t_result res;

    assign stall       = r_out_valid && !o_out.ready;
    assign take        = r_in_valid && !stall;
    assign i_in.ready  = r_live && (!r_in_valid || !stall);

    htrp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_req_type  (r_in_req),
        .i_rx_byte   (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_req  <= i_in.req_type;
            r_in_byte <= i_in.rx_byte;
        end
        if (take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tick_count  = r_out.tick_count;
    assign o_out.digit_count = r_out.digit_count;
    assign o_out.malformed   = r_out.malformed;

endmodule

// ----- rtl/htrp_checker.sv -----
// ----------------------------------------------------------------------------
// htrp_checker
// Port-level checks for the hex tick reply parser, bound to the top level.
// ----------------------------------------------------------------------------
module htrp_checker #(
    parameter int MAX_DIGITS = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_req_type,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_tick_count,
    input logic [3:0]  i_out_digit_count,
    input logic        i_out_malformed
);

    localparam logic [4:0] CNT_LIMIT = (MAX_DIGITS > 15) ? 5'd15 : 5'(MAX_DIGITS);

    // stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_tick_count) && $stable(i_out_digit_count)
            && $stable(i_out_malformed))
        else $error("result changed while stalled");

    // a fresh result comes from a byte word accepted at the input before it
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_req_type, 2))
        else $error("result without a terminating byte");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 5'(i_out_digit_count) <= CNT_LIMIT)
        else $error("digit count beyond limit");

    // no digits means no sign extension
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_digit_count == 4'd0 |-> i_out_tick_count == 32'd0)
        else $error("nonzero value with no digits");

endmodule

bind hex_tick_reply_parser_unit htrp_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_htrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_req_type     (i_in.req_type),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_tick_count  (o_out.tick_count),
    .i_out_digit_count (o_out.digit_count),
    .i_out_malformed   (o_out.malformed)
);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Sends encoder-count replies word by word into the hex tick reply parser,
// predicts each parsed result as words are accepted and checks every field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import htrp_pkg::*;

    localparam int MAX_DIGITS   = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {PARSE_IDLE, PARSE_ECHO, PARSE_DIGITS} t_parse_phase;
    typedef logic [7:0] t_byte_q [$];

    logic clk = 1'b0;
    logic rst_n;

    htrp_in_if  rx_ch ();
    htrp_out_if reply_ch ();

    hex_tick_reply_parser_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (rx_ch.sink),
        .o_out   (reply_ch.source)
    );

    // parser model state
    t_parse_phase p_phase;
    int unsigned  p_echo_left;
    bit           p_first_seen;
    logic [31:0]  p_acc;
    int unsigned  p_digits;
    bit           p_negative;
    bit           p_bad;

    t_result pending_replies [$];
    int      send_idle_pct;
    int      take_idle_pct;
    int      words_sent  = 0;
    int      mismatches  = 0;
    int      idle_cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    function automatic t_byte_q text_bytes(input string s, input logic [7:0] term);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        q.push_back(term);
        return q;
    endfunction

    task automatic clear_parser();
        p_phase      = PARSE_IDLE;
        p_echo_left  = 0;
        p_first_seen = 1'b0;
        p_acc        = '0;
        p_digits     = 0;
        p_negative   = 1'b0;
        p_bad        = 1'b0;
    endtask

    task automatic track_word(input logic req, input logic [7:0] b);
        int          h;
        logic [31:0] v;
        t_result     r;
        if (req == REQ_START) begin
            clear_parser();
            p_phase     = PARSE_ECHO;
            p_echo_left = ECHO_BYTES;
        end else if (p_phase == PARSE_ECHO) begin
            // only the very first byte after a start may be a skipped carriage return
            if (!(!p_first_seen && b == CR_BYTE) && p_echo_left > 0) p_echo_left--;
            p_first_seen = 1'b1;
            if (p_echo_left == 0) p_phase = PARSE_DIGITS;
        end else if (p_phase == PARSE_DIGITS) begin
            if (p_digits >= MAX_DIGITS || b == CR_BYTE) begin
                v = p_acc;
                if (p_negative && 4 * p_digits < 32) v = v | (32'hFFFF_FFFF << (4 * p_digits));
                r.tick_count  = v;
                r.digit_count = (p_digits > 15) ? 4'd15 : 4'(p_digits);
                r.malformed   = p_bad;
                pending_replies.push_back(r);
                p_phase = PARSE_IDLE;
            end else if (!p_bad) begin
                h = nibble_of(b);
                if (h < 0) begin
                    p_bad = 1'b1;
                end else begin
                    if (p_digits == 0 && h >= 8) p_negative = 1'b1;
                    p_acc = {p_acc[27:0], 4'(h)};
                    p_digits++;
                end
            end
        end
    endtask

    task automatic send_word(input logic req, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid    <= 1'b1;
        rx_ch.req_type <= req;
        rx_ch.rx_byte  <= b;
        do @(posedge clk); while (!rx_ch.ready);
        track_word(req, b);
        words_sent++;
    endtask

    task automatic send_reply(input bit lead_cr, input t_byte_q body, input bit allow_cr);
        logic [7:0] e;
        send_word(REQ_START, 8'($urandom));
        if (lead_cr) send_word(REQ_BYTE, CR_BYTE);
        repeat (ECHO_BYTES) begin
            if (allow_cr && $urandom_range(7) == 0) begin
                e = CR_BYTE;
            end else begin
                do e = 8'($urandom); while (e == CR_BYTE);
            end
            send_word(REQ_BYTE, e);
        end
        foreach (body[i]) send_word(REQ_BYTE, body[i]);
    endtask

    task automatic test_idle_and_restart();
        // bytes with no query pending are dropped
        send_word(REQ_BYTE, 8'h31);
        send_word(REQ_BYTE, CR_BYTE);
        send_word(REQ_START, 8'hFF);
        send_word(REQ_BYTE, 8'h45);
        send_word(REQ_BYTE, 8'h45);
        // restart during echo, then during digits
        send_reply(1'b0, text_bytes("12", 8'h34), 1'b0);
        send_reply(1'b0, text_bytes("ABCD", CR_BYTE), 1'b0);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, CR_BYTE);
    endtask

    task automatic test_sign_and_range();
        send_reply(1'b0, text_bytes("7FFFFFFF", 8'hFF), 1'b0);
        send_reply(1'b0, text_bytes("80000000", CR_BYTE), 1'b0);
        send_reply(1'b0, text_bytes("fA", CR_BYTE), 1'b0);
        send_reply(1'b1, text_bytes("00000000", 8'h00), 1'b0);
        send_reply(1'b0, text_bytes("c0dE7", CR_BYTE), 1'b0);
    endtask

    task automatic test_early_and_late_cr();
        t_byte_q body;
        send_reply(1'b1, text_bytes("", CR_BYTE), 1'b0);
        send_reply(1'b0, text_bytes("5", CR_BYTE), 1'b0);
        // a carriage return past the first byte counts as echo
        send_word(REQ_START, 8'h00);
        body = text_bytes("Q\rQQ3", CR_BYTE);
        foreach (body[i]) send_word(REQ_BYTE, body[i]);
        send_word(REQ_START, 8'h5A);
        body = text_bytes("\r\r\r\r\r1", CR_BYTE);
        foreach (body[i]) send_word(REQ_BYTE, body[i]);
    endtask

    task automatic test_malformed_digits();
        send_reply(1'b0, text_bytes("12G4", CR_BYTE), 1'b0);
        send_reply(1'b0, text_bytes("Z9", CR_BYTE), 1'b0);
        send_reply(1'b0, text_bytes("8g", CR_BYTE), 1'b0);
        send_reply(1'b0, text_bytes("1234567/9", CR_BYTE), 1'b0);
    endtask

    task automatic test_random_replies(input int n_words);
        int         stop_at;
        int         kind;
        int         ndig;
        int         bad_at;
        logic [3:0] nib;
        logic [7:0] b;
        t_byte_q    body;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                repeat ($urandom_range(6, 1))
                    send_word(($urandom_range(7) == 0) ? REQ_START : REQ_BYTE, 8'($urandom));
            end else begin
                body.delete();
                ndig = $urandom_range(MAX_DIGITS);
                if (kind < 25) bad_at = $urandom_range(ndig);
                else bad_at = -1;
                for (int i = 0; i <= ndig; i++) begin
                    if (i == bad_at) begin
                        do b = 8'($urandom); while (nibble_of(b) >= 0 || b == CR_BYTE);
                        body.push_back(b);
                    end
                    if (i < ndig) begin
                        nib = 4'($urandom);
                        if (nib < 10) b = 8'h30 + nib;
                        else if ($urandom_range(1)) b = 8'h41 + nib - 8'd10;
                        else b = 8'h61 + nib - 8'd10;
                        body.push_back(b);
                    end
                end
                // a full set of digits takes any byte as terminator
                if (bad_at < 0 && ndig == MAX_DIGITS && $urandom_range(1))
                    body.push_back(8'($urandom));
                else
                    body.push_back(CR_BYTE);
                send_reply(1'($urandom), body, 1'b1);
            end
        end
    endtask

    always @(negedge clk) reply_ch.ready <= ($urandom_range(99) >= take_idle_pct);

    always @(posedge clk) begin : check_reply
        t_result want;
        if (rst_n && reply_ch.valid && reply_ch.ready) begin
            if (pending_replies.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected reply: tick_count %h digit_count %0d malformed %0b",
                             reply_ch.tick_count, reply_ch.digit_count, reply_ch.malformed);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (want.tick_count !== reply_ch.tick_count
                        || want.digit_count !== reply_ch.digit_count
                        || want.malformed !== reply_ch.malformed) begin
                    if (mismatches < 10)
                        $display("reply mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 want.tick_count, want.digit_count, want.malformed,
                                 reply_ch.tick_count, reply_ch.digit_count,
                                 reply_ch.malformed);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (reply_ch.valid && reply_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        rx_ch.valid    = 1'b0;
        rx_ch.req_type = REQ_BYTE;
        rx_ch.rx_byte  = '0;
        reply_ch.ready = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 36;
        take_idle_pct  = 57;
        clear_parser();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_restart();
        test_sign_and_range();
        test_early_and_late_cr();
        test_malformed_digits();
        test_random_replies(180);
        send_idle_pct = 57;
        take_idle_pct = 36;
        test_random_replies(180);
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random_replies(190);

        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/htrp_pkg.sv
rtl/htrp_if.sv
rtl/htrp_parser.sv
rtl/hex_tick_reply_parser_unit.sv
rtl/htrp_checker.sv
dv/testbench.sv
